[src/ftr_pkg.sv]
// Shared types and constants for the fan throttle ramp and bridge PWM block.
// No dependencies; used by every module of the block.
`default_nettype none

package ftr_pkg;

    localparam int PCT_W  = 8;
    localparam int MAG_W  = 7;
    localparam int DUTY_W = 10;

    typedef logic signed [PCT_W-1:0] t_pct;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [DUTY_W-1:0]       t_duty;

    localparam t_pct STEP_PCT   = 8'sd5;
    localparam t_pct SWEEP_HIGH = 8'sd100;
    localparam t_pct SWEEP_LOW  = 8'sd30;
    localparam t_pct PCT_MAX    = 8'sd100;
    localparam t_pct PCT_MIN    = -8'sd100;
    localparam int   FULL_PCT   = 100;

    // configuration register indexes
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_SWEEP  = 1'b1;

    typedef struct packed {
        t_pct target;   // saturated to -100..100
        logic sweep;
    } t_cfg;

endpackage

`default_nettype wire

[src/ftr_cfg.sv]
// Configuration registers: throttle target and sweep enable.
// Depends on ftr_pkg.
`default_nettype none

module ftr_cfg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire  [7:0]       i_cfg_data,
    output ftr_pkg::t_cfg    o_cfg
);

    ftr_pkg::t_pct r_target;
    logic          r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_sweep  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftr_pkg::CFG_TARGET: r_target <= ftr_pkg::t_pct'(i_cfg_data);
                ftr_pkg::CFG_SWEEP:  r_sweep  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate out-of-range targets
    always_comb begin
        o_cfg.sweep = r_sweep;
        if (r_target > ftr_pkg::PCT_MAX) begin
            o_cfg.target = ftr_pkg::PCT_MAX;
        end else if (r_target < ftr_pkg::PCT_MIN) begin
            o_cfg.target = ftr_pkg::PCT_MIN;
        end else begin
            o_cfg.target = r_target;
        end
    end

endmodule

`default_nettype wire

[src/ftr_step.sv]
// Throttle state and per-tick update: slew toward target or 30..100 sweep.
// Depends on ftr_pkg.
`default_nettype none

module ftr_step (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ftr_pkg::t_cfg    i_cfg,
    input  wire              i_advance,
    input  wire              i_tick,
    output ftr_pkg::t_pct    o_level
);

    ftr_pkg::t_pct     r_level;
    logic              r_down;
    ftr_pkg::t_pct     n_level;
    logic              n_down;
    ftr_pkg::t_pct     w_swp;
    logic signed [8:0] w_diff;

    assign w_swp  = r_down ? (r_level - ftr_pkg::STEP_PCT) : (r_level + ftr_pkg::STEP_PCT);
    assign w_diff = $signed({i_cfg.target[7], i_cfg.target}) - $signed({r_level[7], r_level});

    always_comb begin
        n_level = r_level;
        n_down  = r_down;
        if (i_advance && i_tick) begin
            if (i_cfg.sweep) begin
                if (w_swp >= ftr_pkg::SWEEP_HIGH || w_swp <= ftr_pkg::SWEEP_LOW) begin
                    n_down = ~r_down;
                end
                if (w_swp > ftr_pkg::SWEEP_HIGH) begin
                    n_level = ftr_pkg::SWEEP_HIGH;
                end else if (w_swp < ftr_pkg::SWEEP_LOW) begin
                    n_level = ftr_pkg::SWEEP_LOW;
                end else begin
                    n_level = w_swp;
                end
            end else begin
                if (w_diff < 9'sd5 && w_diff > -9'sd5) begin
                    n_level = i_cfg.target;
                end else if (w_diff > 9'sd0) begin
                    n_level = r_level + ftr_pkg::STEP_PCT;
                end else begin
                    n_level = r_level - ftr_pkg::STEP_PCT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_down  <= 1'b0;
        end else begin
            r_level <= n_level;
            r_down  <= n_down;
        end
    end

    assign o_level = n_level;

endmodule

`default_nettype wire

[src/ftr_duty.sv]
// Duty lookup: floor(|level| * DUTY_MAX / 100), steered to bridge side A or B.
// Depends on ftr_pkg; table built at elaboration from DUTY_MAX.
`default_nettype none

module ftr_duty #(
    parameter int DUTY_MAX = 1023
) (
    input  ftr_pkg::t_pct   i_level,
    output ftr_pkg::t_duty  o_duty_a,
    output ftr_pkg::t_duty  o_duty_b
);

    localparam int LutDepth = 2 ** ftr_pkg::MAG_W;

    typedef ftr_pkg::t_duty t_lut [LutDepth];

    function automatic t_lut f_build_lut();
        t_lut        lut;
        logic [31:0] prod;
        for (int m = 0; m < LutDepth; m++) begin
            prod = (32'(m) * 32'(DUTY_MAX)) / ftr_pkg::FULL_PCT;
            if (prod > 32'(DUTY_MAX)) begin
                prod = 32'(DUTY_MAX);
            end
            lut[m] = prod[ftr_pkg::DUTY_W-1:0];
        end
        return lut;
    endfunction

    localparam t_lut DutyLut = f_build_lut();

    ftr_pkg::t_pct  w_abs;
    ftr_pkg::t_mag  w_mag;
    ftr_pkg::t_duty w_duty;

    assign w_abs  = i_level[7] ? -i_level : i_level;
    assign w_mag  = w_abs[ftr_pkg::MAG_W-1:0];
    assign w_duty = DutyLut[w_mag];

    assign o_duty_a = (i_level > 8'sd0) ? w_duty : '0;
    assign o_duty_b = (i_level < 8'sd0) ? w_duty : '0;

endmodule

`default_nettype wire

[src/fan_throttle_ramp_pwm.sv]
// Fan throttle slew-rate limiter with bridge PWM duty outputs (top level).
// Registers: input register, then result register, with the level update and duty lookup
// between them in one stage; a stalled result transfer holds both registers.
// Throughput: one tick per cycle while the result transfer is not stalled.
// Reset (synchronous, active low) clears the level to 0, sweep direction upward,
// target 0, sweep off, and empties both pipeline registers. Uses ftr_cfg, ftr_step, ftr_duty.
`default_nettype none

module fan_throttle_ramp_pwm #(
    parameter int DUTY_MAX = 1023
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_idx,
    input  wire  [7:0]            i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire                   i_tick,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output ftr_pkg::t_pct         o_throttle_now,
    output ftr_pkg::t_duty        o_side_a_duty,
    output ftr_pkg::t_duty        o_side_b_duty
);

    ftr_pkg::t_cfg  w_cfg;
    ftr_pkg::t_pct  w_level;
    ftr_pkg::t_duty w_duty_a;
    ftr_pkg::t_duty w_duty_b;
    logic           w_move;

    logic           r_in_valid;
    logic           r_in_tick;
    logic           r_out_valid;
    ftr_pkg::t_pct  r_throttle;
    ftr_pkg::t_duty r_duty_a;
    ftr_pkg::t_duty r_duty_b;

    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    ftr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ftr_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_advance (w_move),
        .i_tick    (r_in_tick),
        .o_level   (w_level)
    );

    ftr_duty #(
        .DUTY_MAX (DUTY_MAX)
    ) u_duty (
        .i_level  (w_level),
        .o_duty_a (w_duty_a),
        .o_duty_b (w_duty_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_tick <= i_tick;
        end
        if (w_move) begin
            r_throttle <= w_level;
            r_duty_a   <= w_duty_a;
            r_duty_b   <= w_duty_b;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_throttle_now = r_throttle;
    assign o_side_a_duty  = r_duty_a;
    assign o_side_b_duty  = r_duty_b;

endmodule

`default_nettype wire

[src/ftr_checker.sv]
// Port-level checks for fan_throttle_ramp_pwm, attached by bind.
// Depends on ftr_pkg.
`default_nettype none

module ftr_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   o_out_valid,
    input  wire                   i_out_ready,
    input  ftr_pkg::t_pct         o_throttle_now,
    input  ftr_pkg::t_duty        o_side_a_duty,
    input  ftr_pkg::t_duty        o_side_b_duty
);

    // a stalled result transfer keeps valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_throttle_now) && $stable(o_side_a_duty) && $stable(o_side_b_duty))
        else $error("result payload changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_throttle_now <= 8'sd100 && o_throttle_now >= -8'sd100))
        else $error("throttle out of range");

    // duty only on the side matching the throttle sign
    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_throttle_now > 8'sd0 || o_side_a_duty == '0) &&
            (o_throttle_now < 8'sd0 || o_side_b_duty == '0))
        else $error("duty on wrong bridge side");

endmodule

bind fan_throttle_ramp_pwm ftr_checker u_ftr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_throttle_now (o_throttle_now),
    .o_side_a_duty  (o_side_a_duty),
    .o_side_b_duty  (o_side_b_duty)
);

`default_nettype wire

[tb/sv/fan_throttle_ramp_pwm_test.sv]
// Self-checking testbench for fan_throttle_ramp_pwm: slew ramp, sweep fold and bridge duty.
// Predicts each output from its own copy of level, sweep direction and config registers.
// Depends on ftr_pkg and the fan_throttle_ramp_pwm top level.

module fan_throttle_ramp_pwm_test;

    localparam int DUTY_MAX    = 1023;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 30;
    localparam int PHASE_TICKS = 200;

    typedef struct {
        ftr_pkg::t_pct  throttle;
        ftr_pkg::t_duty duty_a;
        ftr_pkg::t_duty duty_b;
    } t_fan_output;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic           i_cfg_idx;
    logic [7:0]     i_cfg_data;
    logic           i_in_valid;
    logic           i_tick;
    logic           i_out_ready = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    ftr_pkg::t_pct  o_throttle_now;
    ftr_pkg::t_duty o_side_a_duty;
    ftr_pkg::t_duty o_side_b_duty;

    // predictor state and its view of the config registers
    int             level_pct;
    logic           sweeping_down;
    ftr_pkg::t_pct  target_reg;
    logic           sweep_reg;

    t_fan_output    throttle_due[$];
    int             cycle_count;
    int             mismatch_count;
    int             ticks_sent;
    int             outputs_checked;
    int             config_writes;
    int             send_idle_pct;
    int             recv_stall_pct;

    fan_throttle_ramp_pwm #(.DUTY_MAX(DUTY_MAX)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_tick         (i_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_throttle_now (o_throttle_now),
        .o_side_a_duty  (o_side_a_duty),
        .o_side_b_duty  (o_side_b_duty)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_full(input int v);
        if (v > int'(ftr_pkg::PCT_MAX)) return int'(ftr_pkg::PCT_MAX);
        if (v < int'(ftr_pkg::PCT_MIN)) return int'(ftr_pkg::PCT_MIN);
        return v;
    endfunction

    function automatic t_fan_output step_throttle(input logic tick_bit);
        int          nxt;
        int          diff;
        int          mag;
        int          duty;
        int          step;
        t_fan_output r;
        step = int'(ftr_pkg::STEP_PCT);
        if (tick_bit) begin
            if (sweep_reg) begin
                nxt = level_pct + (sweeping_down ? -step : step);
                if (nxt >= int'(ftr_pkg::SWEEP_HIGH) || nxt <= int'(ftr_pkg::SWEEP_LOW))
                    sweeping_down = ~sweeping_down;
                if (nxt > int'(ftr_pkg::SWEEP_HIGH)) nxt = int'(ftr_pkg::SWEEP_HIGH);
                if (nxt < int'(ftr_pkg::SWEEP_LOW)) nxt = int'(ftr_pkg::SWEEP_LOW);
                level_pct = nxt;
            end else begin
                diff = clamp_full(int'(target_reg)) - level_pct;
                if (diff < step && diff > -step)
                    level_pct = clamp_full(int'(target_reg));
                else
                    level_pct += (diff > 0) ? step : -step;
            end
            level_pct = clamp_full(level_pct);
        end
        mag  = (level_pct < 0) ? -level_pct : level_pct;
        duty = (mag * DUTY_MAX) / ftr_pkg::FULL_PCT;
        if (duty > DUTY_MAX) duty = DUTY_MAX;
        r.throttle = ftr_pkg::t_pct'(level_pct);
        r.duty_a   = (level_pct > 0) ? ftr_pkg::t_duty'(duty) : '0;
        r.duty_b   = (level_pct < 0) ? ftr_pkg::t_duty'(duty) : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_output();
        t_fan_output want;
        if (throttle_due.size() == 0) begin
            report_mismatch("unexpected output transfer, nothing pending", 1, 0);
        end else begin
            want = throttle_due.pop_front();
            if (o_throttle_now !== want.throttle)
                report_mismatch("throttle_now", int'(o_throttle_now), int'(want.throttle));
            if (o_side_a_duty !== want.duty_a)
                report_mismatch("side_a_duty", int'(o_side_a_duty), int'(want.duty_a));
            if (o_side_b_duty !== want.duty_b)
                report_mismatch("side_b_duty", int'(o_side_b_duty), int'(want.duty_b));
            outputs_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                throttle_due.push_back(step_throttle(i_tick));
            if (o_out_valid && i_out_ready)
                check_output();
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d outputs outstanding",
                 cycle_count, throttle_due.size());
        $display("fan_throttle_ramp_pwm test failed");
        $finish;
    end

    // valid is held across back-to-back transfers; each cycle idles with the set odds
    task automatic send_tick(input logic tick_bit);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tick     <= tick_bit;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic wait_for_outputs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (throttle_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers in consecutive cycles; spare data bits of the sweep write are random
    task automatic write_config(input logic [7:0] target_bits, input logic sweep_bit);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ftr_pkg::CFG_TARGET;
        i_cfg_data <= target_bits;
        @(posedge i_clk);
        target_reg = ftr_pkg::t_pct'(target_bits);
        i_cfg_idx  <= ftr_pkg::CFG_SWEEP;
        i_cfg_data <= {7'($urandom_range(127)), sweep_bit};
        @(posedge i_clk);
        sweep_reg = sweep_bit;
        i_cfg_we  <= 1'b0;
        config_writes++;
    endtask

    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b1);
        wait_for_outputs();
    endtask

    // saturated targets both ways, snap onto a close target, hold on a low tick
    task automatic test_ramp_and_snap();
        write_config(8'h7F, 1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_for_outputs();
        write_config(8'd12, 1'b0);
        send_tick(1'b1);
        wait_for_outputs();
        write_config(8'h80, 1'b0);
        repeat (3) send_tick(1'b1);
        wait_for_outputs();
    endtask

    // sweep entered from a negative level folds up to the low bound twice
    task automatic test_sweep_fold();
        write_config(8'h9C, 1'b1);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        wait_for_outputs();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int         sent;
        int         seg;
        logic [7:0] tgt;
        sent = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < PHASE_TICKS) begin
            wait_for_outputs();
            case ($urandom_range(6))
                0: tgt = 8'h7F;
                1: tgt = 8'h80;
                2: tgt = 8'd100;
                3: tgt = 8'h9C;
                4: tgt = 8'd0;
                default: tgt = 8'($urandom_range(255));
            endcase
            write_config(tgt, $urandom_range(99) < 35);
            seg = $urandom_range(10, 50);
            repeat (seg) send_tick($urandom_range(99) < 90);
            sent += seg;
        end
        wait_for_outputs();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= ftr_pkg::CFG_TARGET;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_tick         <= 1'b0;
        level_pct      = 0;
        sweeping_down  = 1'b0;
        target_reg     = '0;
        sweep_reg      = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        ticks_sent     = 0;
        outputs_checked = 0;
        config_writes  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_ramp_and_snap();
        test_sweep_fold();
        test_random_phase(0, 0);
        test_random_phase(67, 0);
        test_random_phase(0, 67);
        test_random_phase(34, 34);

        repeat (10) @(posedge i_clk);
        $display("ran %0d ticks through %0d config settings, ramp and sweep modes,",
                 ticks_sent, config_writes);
        $display("under four idle and stall mixes; %0d outputs compared field by field",
                 outputs_checked);
        if (mismatch_count == 0 && throttle_due.size() == 0) begin
            $display("fan_throttle_ramp_pwm test passed");
        end else begin
            $display("fan_throttle_ramp_pwm test failed");
        end
        $finish;
    end

endmodule
